// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the event filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define RLEF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define RLEF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/rlef_pkg.sv =====
// Types and constants of the rate-limited event filter.
package rlef_pkg;

  typedef enum logic [1:0] {
    KIND_RAISE   = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_DISABLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PARAM    = 2'd1,
    STATUS_DISABLED = 2'd2,
    STATUS_RATE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] evt_id;
    logic [7:0]  severity;
    logic [7:0]  aux_length;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        report_valid;
    logic [2:0]  report_subtype;
    logic [22:0] report_seconds;
    logic [15:0] report_event;
    logic [31:0] event_raise_count;
    logic [31:0] info_count;
    logic [31:0] low_count;
    logic [31:0] medium_count;
    logic [31:0] high_count;
  } rsp_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] last_time;
    logic [31:0] raise_count;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  localparam logic [15:0] MIN_INTERVAL_RESET = 16'd100;
  localparam logic [7:0]  SEVERITY_LEVELS    = 8'd4;

  // Division by 1000 of a 32-bit value as (n * DIV1000_MUL) >> DIV1000_SHIFT, exact.
  localparam int unsigned DIV1000_MUL_W = 29;
  localparam int unsigned DIV1000_PROD_W = 32 + DIV1000_MUL_W;
  localparam int unsigned DIV1000_SHIFT = 38;
  localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 29'd274877907;

endpackage

// ===== hw/rtl/rate_limited_event_filter.sv =====
// Top level of the rate-limited event filter: controller and datapath.
// A request is taken when start is high and busy is low; the request and its table entry are registered,
// then the execute state writes the result register. No new request is taken while it executes.
// result_valid_o is high for exactly one cycle and cannot be stalled; result_o holds until the next execution.
// After reset a sweep writes all EVENT_SLOTS entries of the event table while busy is high.
// Configuration writes are taken in any cycle, the sweep included.
`include "assert_macros.svh"

module rate_limited_event_filter #(
  parameter int unsigned EVENT_SLOTS   = 64,
  parameter int unsigned MAX_AUX_BYTES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rlef_pkg::req_t  req_i,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  output logic            result_valid_o,
  output rlef_pkg::rsp_t  result_o
);

  rlef_pkg::ctrl_cmd_t  cmd;
  rlef_pkg::dp_status_t dp_status;

  rlef_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .status_i (dp_status)
  );

  rlef_datapath #(
    .EVENT_SLOTS   (EVENT_SLOTS),
    .MAX_AUX_BYTES (MAX_AUX_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `RLEF_ASSERT(a_accept_sets_busy, start && !busy |=> busy, "busy not raised after a request")
  `RLEF_ASSERT(a_result_after_exec, result_valid_o |-> $past(busy), "result without execution")
  `RLEF_ASSERT(a_single_strobe, result_valid_o |=> !result_valid_o, "result strobe too long")
  `RLEF_ASSERT(a_report_is_ok,
               result_valid_o && result_o.report_valid |->
               result_o.status == rlef_pkg::STATUS_OK, "report with failing status")
  `RLEF_ASSERT_ALWAYS(a_reset_idle_out, !rst_ni |-> result_valid_o !== 1'b1,
                      "result strobe during reset")

endmodule

// ===== hw/rtl/rlef_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rlef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rlef_ctrl.sv =====
// Controller state machine of the event filter: clearing sweep, accept and execute.
module rlef_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output rlef_pkg::ctrl_cmd_t    cmd_o,
  input  rlef_pkg::dp_status_t   status_i
);

  rlef_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlef_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlef_pkg::S_CLEAR: begin
        if (status_i.clear_last) begin
          state_d = rlef_pkg::S_IDLE;
        end
      end
      rlef_pkg::S_IDLE: begin
        if (start) begin
          state_d = rlef_pkg::S_EXEC;
        end
      end
      rlef_pkg::S_EXEC: begin
        state_d = rlef_pkg::S_IDLE;
      end
      default: begin
        state_d = rlef_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd_o.clear = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      rlef_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      rlef_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      rlef_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rlef_datapath.sv =====
// Datapath of the event filter: event table, checks, counters and result register.
module rlef_datapath #(
  parameter int unsigned EVENT_SLOTS   = 64,
  parameter int unsigned MAX_AUX_BYTES = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rlef_pkg::ctrl_cmd_t    cmd_i,
  output rlef_pkg::dp_status_t   status_o,
  input  rlef_pkg::req_t         req_i,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_wdata_i,
  output logic                   result_valid_o,
  output rlef_pkg::rsp_t         result_o
);

  localparam int unsigned AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int unsigned EW = $bits(rlef_pkg::entry_t);

  logic [15:0]           min_interval_q;
  rlef_pkg::req_t        req_q;
  logic [AW-1:0]         clr_cnt_q;
  logic [31:0]           sev_cnt_q [4];
  logic [31:0]           sev_cnt_d [4];
  logic                  result_valid_q;
  rlef_pkg::rsp_t        result_q, result_d;

  rlef_pkg::entry_t      rd_entry, exec_entry, wr_entry;
  logic                  exec_we, ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_rdata;

  logic                  in_range, sev_ok, aux_ok, rate_ok, raise_ok;
  logic [31:0]           elapsed;
  logic [31:0]           count_inc;
  logic [rlef_pkg::DIV1000_PROD_W-1:0] product;

  rlef_ram #(
    .WIDTH (EW),
    .DEPTH (EVENT_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (req_i.evt_id[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = rlef_pkg::entry_t'(ram_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= rlef_pkg::MIN_INTERVAL_RESET;
    end else if (cfg_we_i) begin
      min_interval_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign status_o.clear_last = (clr_cnt_q == AW'(EVENT_SLOTS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  assign in_range  = req_q.evt_id < 16'(EVENT_SLOTS);
  assign sev_ok    = req_q.severity < rlef_pkg::SEVERITY_LEVELS;
  assign aux_ok    = req_q.aux_length <= 8'(MAX_AUX_BYTES);
  assign elapsed   = req_q.now_ms - rd_entry.last_time;
  assign rate_ok   = elapsed >= {16'd0, min_interval_q};
  assign count_inc = rd_entry.raise_count + 32'd1;
  assign product   = rlef_pkg::DIV1000_PROD_W'(req_q.now_ms)
                   * rlef_pkg::DIV1000_PROD_W'(rlef_pkg::DIV1000_MUL);

  always_comb begin
    exec_entry = rd_entry;
    exec_we    = 1'b0;
    raise_ok   = 1'b0;
    result_d   = '0;
    result_d.status = rlef_pkg::STATUS_PARAM;
    unique case (req_q.kind) inside
      rlef_pkg::KIND_RAISE: begin
        if (!in_range || !sev_ok || !aux_ok) begin
          result_d.status = rlef_pkg::STATUS_PARAM;
        end else if (!rd_entry.enable) begin
          result_d.status = rlef_pkg::STATUS_DISABLED;
        end else if (!rate_ok) begin
          result_d.status = rlef_pkg::STATUS_RATE;
        end else begin
          raise_ok               = 1'b1;
          exec_we                = 1'b1;
          exec_entry.last_time   = req_q.now_ms;
          exec_entry.raise_count = count_inc;
          result_d.status        = rlef_pkg::STATUS_OK;
          result_d.report_valid  = 1'b1;
          result_d.report_subtype = {1'b0, req_q.severity[1:0]} + 3'd1;
          result_d.report_seconds =
            product[rlef_pkg::DIV1000_PROD_W-1:rlef_pkg::DIV1000_SHIFT];
          result_d.report_event  = req_q.evt_id;
        end
      end
      rlef_pkg::KIND_ENABLE, rlef_pkg::KIND_DISABLE: begin
        if (in_range) begin
          exec_we           = 1'b1;
          exec_entry.enable = (req_q.kind == rlef_pkg::KIND_ENABLE);
          result_d.status   = rlef_pkg::STATUS_OK;
        end
      end
      default: begin
        result_d.status = rlef_pkg::STATUS_PARAM;
      end
    endcase

    for (int i = 0; i < 4; i++) begin
      sev_cnt_d[i] = sev_cnt_q[i];
    end
    if (raise_ok) begin
      sev_cnt_d[req_q.severity[1:0]] = sev_cnt_q[req_q.severity[1:0]] + 32'd1;
    end

    result_d.event_raise_count = in_range ? exec_entry.raise_count : 32'd0;
    result_d.info_count        = sev_cnt_d[0];
    result_d.low_count         = sev_cnt_d[1];
    result_d.medium_count      = sev_cnt_d[2];
    result_d.high_count        = sev_cnt_d[3];
  end

  always_comb begin
    if (cmd_i.clear) begin
      ram_we               = 1'b1;
      ram_waddr            = clr_cnt_q;
      wr_entry.enable      = 1'b1;
      wr_entry.last_time   = 32'd0;
      wr_entry.raise_count = 32'd0;
    end else begin
      ram_we    = cmd_i.exec && exec_we;
      ram_waddr = req_q.evt_id[AW-1:0];
      wr_entry  = exec_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        sev_cnt_q[i] <= 32'd0;
      end
    end else if (cmd_i.exec) begin
      for (int i = 0; i < 4; i++) begin
        sev_cnt_q[i] <= sev_cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
